/* sv/csag_pkg.sv */
// ----------------------------------------------------------------------------
// csag_pkg
// Shared types and constants for the concat strided address generator.
// ----------------------------------------------------------------------------
package csag_pkg;

    localparam int unsigned CFG_DIMS        = 4;
    localparam int unsigned DEF_MAX_DIMS    = 4;
    localparam int unsigned DEF_INDEX_BITS  = 32;
    localparam int unsigned FIELD_W         = 32;
    localparam int unsigned CFG_IDX_W       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_CONCAT_DIM  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM1   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM2   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM3   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_DIM0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_DIM1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_DIM2 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_DIM3 = 4'd7;

    typedef struct packed {
        logic [FIELD_W-1:0] element_index;
        logic [FIELD_W-1:0] part_start;
        logic [FIELD_W-1:0] part_extent;
    } t_csag_in;

    typedef struct packed {
        logic [FIELD_W-1:0] dest_address;
        logic [FIELD_W-1:0] source_index;
    } t_csag_out;

    // fields that ride alongside the index through the pipeline
    typedef struct packed {
        logic [FIELD_W-1:0] source_index;
        logic [FIELD_W-1:0] part_start;
        logic [FIELD_W-1:0] part_extent;
        logic [FIELD_W-1:0] offset;
    } t_csag_side;

endpackage

/* sv/csag_div.sv */
// ----------------------------------------------------------------------------
// csag_div
// Fully pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module csag_div
    import csag_pkg::*;
#(
    parameter int unsigned W = DEF_INDEX_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [W-1:0]     i_dividend,
    input  logic [W-1:0]     i_divisor,
    input  t_csag_side       i_side,
    output logic             o_valid,
    output logic [W-1:0]     o_quot,
    output logic [W-1:0]     o_rem,
    output t_csag_side       o_side
);

    logic             r_v    [W];
    logic [W-1:0]     r_r    [W];
    logic [W-1:0]     r_qd   [W];
    logic [W-1:0]     r_d    [W];
    t_csag_side       r_side [W];

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic             p_v;
        logic [W-1:0]     p_r;
        logic [W-1:0]     p_qd;
        logic [W-1:0]     p_d;
        t_csag_side       p_side;
        logic [W:0]       t;
        logic [W:0]       diff;
        logic             ge;
        logic [W-1:0]     n_r;
        logic [W-1:0]     n_qd;

        if (s == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_r    = '0;
            assign p_qd   = i_dividend;
            assign p_d    = i_divisor;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[s-1];
            assign p_r    = r_r[s-1];
            assign p_qd   = r_qd[s-1];
            assign p_d    = r_d[s-1];
            assign p_side = r_side[s-1];
        end

        always_comb begin
            t    = {p_r, p_qd[W-1]};
            diff = t - {1'b0, p_d};
            ge   = (t >= {1'b0, p_d});
            n_r  = ge ? diff[W-1:0] : t[W-1:0];
            n_qd = {p_qd[W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= p_v;
            end
            r_r[s]    <= n_r;
            r_qd[s]   <= n_qd;
            r_d[s]    <= p_d;
            r_side[s] <= p_side;
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quot  = r_qd[W-1];
    assign o_rem   = r_r[W-1];
    assign o_side  = r_side[W-1];

endmodule

/* sv/csag_dim.sv */
// ----------------------------------------------------------------------------
// csag_dim
// One dimension: divide, multiply remainder by stride, accumulate offset.
// ----------------------------------------------------------------------------
module csag_dim
    import csag_pkg::*;
#(
    parameter int unsigned W = DEF_INDEX_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [W-1:0]       i_lin,
    input  logic [W-1:0]       i_divisor,
    input  logic [FIELD_W-1:0] i_stride,
    input  t_csag_side         i_side,
    output logic               o_valid,
    output logic [W-1:0]       o_quot,
    output t_csag_side         o_side
);

    logic               d_valid;
    logic [W-1:0]       d_quot;
    logic [W-1:0]       d_rem;
    t_csag_side         d_side;

    logic               r_mv;
    logic [FIELD_W-1:0] r_prod;
    logic [W-1:0]       r_mq;
    t_csag_side         r_mside;

    logic               r_av;
    logic [W-1:0]       r_aq;
    t_csag_side         r_aside;
    t_csag_side         n_aside;

    csag_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_dividend (i_lin),
        .i_divisor  (i_divisor),
        .i_side     (i_side),
        .o_valid    (d_valid),
        .o_quot     (d_quot),
        .o_rem      (d_rem),
        .o_side     (d_side)
    );

    always_comb begin
        n_aside        = r_mside;
        n_aside.offset = r_mside.offset + r_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_av <= 1'b0;
        end else begin
            r_mv <= d_valid;
            r_av <= r_mv;
        end
        r_prod  <= FIELD_W'(FIELD_W'(d_rem) * i_stride);
        r_mq    <= d_quot;
        r_mside <= d_side;
        r_aq    <= r_mq;
        r_aside <= n_aside;
    end

    assign o_valid = r_av;
    assign o_quot  = r_aq;
    assign o_side  = r_aside;

endmodule

/* sv/csag_final.sv */
// ----------------------------------------------------------------------------
// csag_final
// Outermost coordinate and start offset terms, final sum and masking.
// ----------------------------------------------------------------------------
module csag_final
    import csag_pkg::*;
#(
    parameter int unsigned W = DEF_INDEX_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [W-1:0]       i_lin,
    input  logic [FIELD_W-1:0] i_stride_outer,
    input  logic [FIELD_W-1:0] i_stride_cat,
    input  t_csag_side         i_side,
    output logic               o_valid,
    output t_csag_out          o_result
);

    localparam logic [FIELD_W-1:0] MASK = FIELD_W'((64'd1 << W) - 64'd1);

    logic               r_pv;
    logic [FIELD_W-1:0] r_p_lin;
    logic [FIELD_W-1:0] r_p_start;
    logic [FIELD_W-1:0] r_off;
    logic [FIELD_W-1:0] r_src;
    logic               r_ov;
    t_csag_out          r_out;
    t_csag_out          n_out;

    always_comb begin
        n_out.dest_address = (r_off + r_p_lin + r_p_start) & MASK;
        n_out.source_index = r_src;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_pv <= i_valid;
            r_ov <= r_pv;
        end
        r_p_lin   <= FIELD_W'(FIELD_W'(i_lin) * i_stride_outer);
        r_p_start <= FIELD_W'((i_side.part_start & MASK) * i_stride_cat);
        r_off     <= i_side.offset;
        r_src     <= i_side.source_index;
        r_out     <= n_out;
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

endmodule

/* sv/concat_strided_address_gen_core.sv */
// ----------------------------------------------------------------------------
// concat_strided_address_gen_core
// Maps an input tensor element index to its address in the concatenated
// output tensor.
// ----------------------------------------------------------------------------
//  channel   | signals                                | handshake
//  ----------+----------------------------------------+-----------------------
//  command   | start, busy, i_cmd                     | start && !busy
//  result    | o_result_valid, o_result               | strobe, no back-pressure
//  config    | i_cfg_valid, o_cfg_ready, index, data  | valid && ready
//
//  One transaction enters every cycle; busy is never raised.
//  Each used dimension but the outermost passes a bit-per-stage divider, then
//  a multiply and an accumulate register; csag_final registers the products, then the sum.
//  Synchronous active-low reset clears all valid bits and resets the config registers.
//  The result side cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module concat_strided_address_gen_core
    import csag_pkg::*;
#(
    parameter int unsigned MAX_DIMS   = DEF_MAX_DIMS,
    parameter int unsigned INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_csag_in             i_cmd,
    output logic                 o_result_valid,
    output t_csag_out            o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FIELD_W-1:0]   i_cfg_data
);

    localparam int unsigned D     = (MAX_DIMS > CFG_DIMS) ? CFG_DIMS :
                                    ((MAX_DIMS < 1) ? 1 : MAX_DIMS);
    localparam int unsigned OUTER = CFG_DIMS - D;
    localparam int unsigned IW    = (INDEX_BITS > FIELD_W) ? FIELD_W : INDEX_BITS;
    localparam int unsigned LAT   = (D - 1) * (IW + 2) + 2;

    logic [1:0]         r_concat_dim;
    logic [FIELD_W-1:0] r_size   [CFG_DIMS];
    logic [FIELD_W-1:0] r_stride [CFG_DIMS];

    logic               c_valid [D];
    logic [IW-1:0]      c_lin   [D];
    t_csag_side         c_side  [D];
    t_csag_side         in_side;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_concat_dim <= '0;
            for (int k = 0; k < CFG_DIMS; k++) begin
                r_size[k]   <= FIELD_W'(1);
                r_stride[k] <= '0;
            end
            r_stride[CFG_DIMS-1] <= FIELD_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CONCAT_DIM:  r_concat_dim <= i_cfg_data[1:0];
                CFG_SIZE_DIM1:   r_size[1]    <= i_cfg_data;
                CFG_SIZE_DIM2:   r_size[2]    <= i_cfg_data;
                CFG_SIZE_DIM3:   r_size[3]    <= i_cfg_data;
                CFG_STRIDE_DIM0: r_stride[0]  <= i_cfg_data;
                CFG_STRIDE_DIM1: r_stride[1]  <= i_cfg_data;
                CFG_STRIDE_DIM2: r_stride[2]  <= i_cfg_data;
                CFG_STRIDE_DIM3: r_stride[3]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_side.source_index = i_cmd.element_index;
        in_side.part_start   = i_cmd.part_start;
        in_side.part_extent  = i_cmd.part_extent;
        in_side.offset       = '0;
    end

    assign c_valid[0] = start && !busy;
    assign c_lin[0]   = i_cmd.element_index[IW-1:0];
    assign c_side[0]  = in_side;

    // innermost dimension first
    for (genvar k = 0; k < D - 1; k++) begin : g_dim
        localparam int unsigned DIM = CFG_DIMS - 1 - k;
        logic [IW-1:0] divisor;

        assign divisor = (r_concat_dim == 2'(DIM)) ? c_side[k].part_extent[IW-1:0]
                                                   : r_size[DIM][IW-1:0];

        csag_dim #(.W(IW)) u_dim (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (c_valid[k]),
            .i_lin     (c_lin[k]),
            .i_divisor (divisor),
            .i_stride  (r_stride[DIM]),
            .i_side    (c_side[k]),
            .o_valid   (c_valid[k+1]),
            .o_quot    (c_lin[k+1]),
            .o_side    (c_side[k+1])
        );
    end

    csag_final #(.W(IW)) u_final (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (c_valid[D-1]),
        .i_lin          (c_lin[D-1]),
        .i_stride_outer (r_stride[OUTER]),
        .i_stride_cat   (r_stride[r_concat_dim]),
        .i_side         (c_side[D-1]),
        .o_valid        (o_result_valid),
        .o_result       (o_result)
    );

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe after reset");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_result_valid)
        else $error("accepted transaction did not produce a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, LAT))
        else $error("result without a transaction");

    a_source_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_result.source_index == $past(i_cmd.element_index, LAT))
        else $error("source index mismatch");

endmodule

/* bench/tb_concat_strided_address_gen_core.sv */
// ----------------------------------------------------------------------------
// tb_concat_strided_address_gen_core
// Drives element transactions through the concat address generator under a
// series of register settings. A table of edge cases runs first, then random
// traffic. Every result is checked in order against a model of the address
// calculation kept inside this bench, or against a given known address.
// ----------------------------------------------------------------------------
module tb_concat_strided_address_gen_core;
    import csag_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd11;
    localparam int SETTLE_CYCLES = 140;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_csag_in             i_cmd;
    logic                 o_result_valid;
    t_csag_out            o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [FIELD_W-1:0]   i_cfg_data;

    concat_strided_address_gen_core DUT (.*);

    logic [1:0]  mdl_concat;
    logic [31:0] mdl_size [4];
    logic [31:0] mdl_stride [4];
    t_csag_out   pending_addrs [$];
    int          err_cnt = 0;
    bit          idle_en = 1;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    initial begin
        #20_000_000;
        $display("FAIL concat_strided_address_gen_core");
        $finish;
    end

    function automatic logic [31:0] dest_addr(t_csag_in c);
        logic [63:0] lin, dv, q, r;
        logic [31:0] off;
        lin = c.element_index;
        off = '0;
        for (int d = 3; d > 0; d--) begin
            dv = (d == mdl_concat) ? c.part_extent : mdl_size[d];
            if (dv == 0) begin
                q = 64'hFFFF_FFFF;
                r = lin;
            end else begin
                q = lin / dv;
                r = lin % dv;
            end
            off = off + 32'(r * mdl_stride[d]);
            lin = q;
        end
        off = off + 32'(lin * mdl_stride[0]);
        off = off + 32'(64'(c.part_start) * mdl_stride[mdl_concat]);
        return off;
    endfunction

    // valid stays high for back-to-back writes; the caller drops it after the batch
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CONCAT_DIM:  mdl_concat = val[1:0];
            CFG_SIZE_DIM1:   mdl_size[1] = val;
            CFG_SIZE_DIM2:   mdl_size[2] = val;
            CFG_SIZE_DIM3:   mdl_size[3] = val;
            CFG_STRIDE_DIM0: mdl_stride[0] = val;
            CFG_STRIDE_DIM1: mdl_stride[1] = val;
            CFG_STRIDE_DIM2: mdl_stride[2] = val;
            CFG_STRIDE_DIM3: mdl_stride[3] = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_addrs.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // known: use the given address instead of the model
    task automatic issue(t_csag_in c, bit known, logic [31:0] addr);
        while (idle_en && $urandom_range(99) < 7) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_addrs.push_back('{known ? addr : dest_addr(c), c.element_index});
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_addrs.size() == 0) begin
                $error("unexpected result transaction");
                err_cnt++;
            end else begin
                t_csag_out e;
                e = pending_addrs.pop_front();
                if (o_result.dest_address !== e.dest_address) begin
                    $error("dest_address exp %h got %h", e.dest_address,
                           o_result.dest_address);
                    err_cnt++;
                end
                if (o_result.source_index !== e.source_index) begin
                    $error("source_index exp %h got %h", e.source_index,
                           o_result.source_index);
                    err_cnt++;
                end
            end
        end
    end

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(5))
            0: return 32'hFFFF_FFFF;
            1: return $urandom_range(1, 2);
            2, 3: return $urandom_range(1, 9);
            default: return $urandom;
        endcase
    endfunction

    t_csag_in edge_rows [] = '{
        '{32'd0,          32'd0,          32'd1},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF},
        '{32'hFFFF_FFFF,  32'd0,          32'd1},
        '{32'd0,          32'hFFFF_FFFF,  32'd1},
        '{32'd1,          32'd1,          32'd0},
        '{32'hDEAD_BEEF,  32'd7,          32'd0},
        '{32'h5555_5555,  32'hAAAA_AAAA,  32'h5555_5555},
        '{32'hAAAA_AAAA,  32'h5555_5555,  32'hAAAA_AAAA},
        '{32'd12345,      32'd3,          32'd5},
        '{32'h8000_0000,  32'h8000_0000,  32'h8000_0000},
        '{32'd7,          32'd2,          32'd8},
        '{32'd100,        32'd1,          32'd3}
    };

    initial begin
        t_csag_in c;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        mdl_concat = 2'd0;
        mdl_size   = '{32'd1, 32'd1, 32'd1, 32'd1};
        mdl_stride = '{32'd0, 32'd0, 32'd0, 32'd1};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: inner sizes are 1 and stride of dim 0 is 0
        foreach (edge_rows[k]) issue(edge_rows[k], 1'b1, 32'd0);
        drain();

        cfg_write(CFG_CONCAT_DIM, 32'hFFFF_FFFF);
        cfg_write(CFG_SIZE_DIM1, 32'hFFFF_FFFF);
        cfg_write(CFG_SIZE_DIM2, 32'hFFFF_FFFF);
        cfg_write(CFG_SIZE_DIM3, 32'hFFFF_FFFF);
        cfg_write(CFG_STRIDE_DIM0, 32'hFFFF_FFFF);
        cfg_write(CFG_STRIDE_DIM1, 32'hFFFF_FFFF);
        cfg_write(CFG_STRIDE_DIM2, 32'hFFFF_FFFF);
        cfg_write(CFG_STRIDE_DIM3, 32'hFFFF_FFFF);
        cfg_write(CFG_UNUSED_IDX, 32'd3);
        i_cfg_valid <= 1'b0;
        foreach (edge_rows[k]) issue(edge_rows[k], 1'b0, 32'd0);
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            idle_en = (ph != 4);
            cfg_write(CFG_CONCAT_DIM, $urandom);
            for (int r = 1; r < 4; r++)
                cfg_write(CFG_SIZE_DIM1 + CFG_IDX_W'(r - 1),
                          (ph == 10) ? 32'd1 : rnd_word());
            for (int r = 0; r < 4; r++)
                cfg_write(CFG_STRIDE_DIM0 + CFG_IDX_W'(r),
                          (ph == 10) ? 32'd0 : rnd_word());
            if ($urandom_range(1)) cfg_write(CFG_UNUSED_IDX, $urandom);
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < 150; n++) begin
                c.element_index = ($urandom_range(2) == 0) ? $urandom
                                                           : $urandom_range(0, 4000);
                c.part_start    = rnd_word() - ($urandom_range(3) == 0);
                c.part_extent   = ($urandom_range(49) == 0) ? 32'd0 : rnd_word();
                issue(c, 1'b0, 32'd0);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pending_addrs.size() == 0)
            $display("PASS concat_strided_address_gen_core");
        else
            $display("FAIL concat_strided_address_gen_core");
        $finish;
    end

endmodule
